// ===== hw/rtl/qwt_pkg.sv =====
// package for the quoted word tokenizer
// types, byte constants and the queue entry format shared by every module
`default_nettype none

package qwt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE     = 2'd0,
    Q_DOUBLE   = 2'd1,
    Q_SINGLE   = 2'd2,
    Q_BACKTICK = 2'd3
  } quote_t;

  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_HASH     = 8'h23;

  // results caused by one input transaction, emitted in field order
  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       has_end;
    logic       has_status;
    logic       err;
  } bundle_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qwt_front.sv =====
// front end of the quoted word tokenizer: accepts bytes, tracks quote/escape state
// and builds one result bundle per transaction; depends on qwt_pkg
`default_nettype none

module qwt_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_tvalid,
  input  wire logic [7:0]     cfg_tdata,
  input  wire logic           in_accept,
  input  wire logic           in_char_valid,
  input  wire logic [7:0]     in_char,
  input  wire logic           in_last,
  output logic                push,
  output qwt_pkg::bundle_t    push_data
);
  import qwt_pkg::*;

  logic   keep_r;
  logic   esc_r, esc_nxt;
  quote_t quote_r, quote_nxt;
  logic   cmt_r, cmt_nxt;
  logic   word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r  <= 1'b0;
      esc_r   <= 1'b0;
      quote_r <= Q_NONE;
      cmt_r   <= 1'b0;
      word_r  <= 1'b0;
    end else begin
      if (cfg_tvalid) begin
        keep_r <= cfg_tdata[0];
      end
      if (in_accept) begin
        esc_r   <= esc_nxt;
        quote_r <= quote_nxt;
        cmt_r   <= cmt_nxt;
        word_r  <= word_nxt;
      end
    end
  end

  always_comb begin
    quote_t q;
    logic   plain;
    logic   add;
    logic   endw;
    esc_nxt   = esc_r;
    quote_nxt = quote_r;
    cmt_nxt   = cmt_r;
    word_nxt  = word_r;
    push_data = '0;
    push_data.ch = in_char;
    add   = 1'b0;
    endw  = 1'b0;
    plain = !esc_r && (quote_r == Q_NONE);
    case (in_char)
      CH_DQUOTE:   q = Q_DOUBLE;
      CH_SQUOTE:   q = Q_SINGLE;
      CH_BACKTICK: q = Q_BACKTICK;
      default:     q = Q_NONE;
    endcase
    if (in_char_valid && !cmt_r) begin
      if (in_char == CH_BSLASH) begin
        add     = esc_r;
        esc_nxt = !esc_r;
      end else begin
        if (in_char == CH_SPACE) begin
          if (plain) endw = 1'b1;
          else       add  = 1'b1;
        end else if (q != Q_NONE) begin
          if (!esc_r && quote_r == q) begin
            endw      = 1'b1;
            quote_nxt = Q_NONE;
          end else if (plain) begin
            quote_nxt = q;
          end else begin
            add = 1'b1;
          end
        end else if (in_char == CH_HASH) begin
          if (plain && keep_r) cmt_nxt = 1'b1;
          else                 add     = 1'b1;
        end else begin
          add = 1'b1;
        end
        esc_nxt = 1'b0;
      end
    end
    if (add) begin
      push_data.has_char = 1'b1;
      word_nxt = 1'b1;
    end
    if (endw && word_r) begin
      push_data.has_end = 1'b1;
      word_nxt = 1'b0;
    end
    if (in_last) begin
      push_data.has_status = 1'b1;
      if (esc_nxt || quote_nxt != Q_NONE) begin
        push_data.err = 1'b1;
      end else if (word_nxt) begin
        push_data.has_end = 1'b1;
      end
      esc_nxt   = 1'b0;
      quote_nxt = Q_NONE;
      cmt_nxt   = 1'b0;
      word_nxt  = 1'b0;
    end
  end

  assign push = in_accept &&
                (push_data.has_char || push_data.has_end || push_data.has_status);

`ifndef SYNTHESIS
  // a word end is only queued while a word was open
  a_end_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.has_end && !push_data.has_char |-> word_r)
    else $error("word end queued with no open word");
  // a comment swallows bytes
  a_comment_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && cmt_r |-> !push_data.has_char)
    else $error("result produced inside a comment");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/qwt_fifo.sv =====
// short queue of result bundles between the front and back of the tokenizer
// register based, one push and one pop per cycle; depends on qwt_pkg
`default_nettype none

module qwt_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  qwt_pkg::bundle_t   push_data,
  output logic               full,
  output logic               head_valid,
  output qwt_pkg::bundle_t   head,
  input  wire logic          pop
);
  import qwt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/qwt_back.sv =====
// back end of the tokenizer: turns each queued bundle into one result per cycle while
// out_tready is high, through a registered output stage; depends on qwt_pkg
`default_nettype none

module qwt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  qwt_pkg::bundle_t   head,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import qwt_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  kind_t      kind_r;
  logic       last_r;
  logic       char_done_r, char_done_nxt;
  logic       end_done_r, end_done_nxt;

  logic       load;
  logic       rem_char, rem_end;
  kind_t      kind_sel;
  logic       final_part;

  assign rem_char = head.has_char && !char_done_r;
  assign rem_end  = head.has_end && !end_done_r;
  assign load     = head_valid && (!valid_r || out_tready);
  assign pop      = load && final_part;

  always_comb begin
    char_done_nxt = char_done_r;
    end_done_nxt  = end_done_r;
    if (rem_char) begin
      kind_sel      = KIND_CHAR;
      final_part    = !(head.has_end || head.has_status);
      char_done_nxt = 1'b1;
    end else if (rem_end) begin
      kind_sel     = KIND_END;
      final_part   = !head.has_status;
      end_done_nxt = 1'b1;
    end else begin
      kind_sel   = head.err ? KIND_ERR : KIND_OK;
      final_part = 1'b1;
    end
    if (final_part) begin
      char_done_nxt = 1'b0;
      end_done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      char_done_r <= 1'b0;
      end_done_r  <= 1'b0;
    end else begin
      if (load) begin
        valid_r     <= 1'b1;
        char_done_r <= char_done_nxt;
        end_done_r  <= end_done_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_sel;
      data_r <= (kind_sel == KIND_CHAR) ? head.ch : 8'h00;
      last_r <= final_part;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  // a done status always closes the run of its transaction
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_OK || out_tuser == KIND_ERR) |-> out_tlast)
    else $error("status result not marked last");
  a_partial_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    char_done_r || end_done_r |-> head_valid)
    else $error("bundle progress kept with empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/quoted_word_tokenizer.sv =====
// quoted word tokenizer: splits a byte stream into words with quotes, escapes, comments
// path: each input transaction is queued, then its results leave through the registered output stage
// throughput: one input per cycle while the queue has room, one result per cycle out while
// out_tready is high; an input with n results holds the output stage until the back end has sent all n
// reset: synchronous, clears quote/escape/comment/word state, keep_comments and the queue
`default_nettype none

module quoted_word_tokenizer #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_tvalid,
  output logic            cfg_tready,
  input  wire logic [7:0] cfg_tdata,   // [0] keep_comments, [7:1] zero
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] character
  input  wire logic [0:0] in_tuser,    // [0] char_valid
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] character_res
  output logic [1:0]      out_tuser,   // [1:0] kind
  output logic            out_tlast
);
  import qwt_pkg::*;

  logic    in_accept;
  logic    push, full, head_valid, pop;
  bundle_t push_data, head;

  assign cfg_tready = 1'b1;
  assign in_tready  = !full;
  assign in_accept  = in_tvalid && in_tready;

  qwt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_tvalid    (cfg_tvalid),
    .cfg_tdata     (cfg_tdata),
    .in_accept     (in_accept),
    .in_char_valid (in_tuser[0]),
    .in_char       (in_tdata),
    .in_last       (in_tlast),
    .push          (push),
    .push_data     (push_data)
  );

  qwt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  qwt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
